@@ hw/rtl/wrm_pkg.sv @@
// ----------------------------------------------------------------------------
// Windowed rate meter package
// Shared sizes, window constants, operation codes, payload and control types.
// ----------------------------------------------------------------------------
package wrm_pkg;

	localparam int SLOT_COUNT = 256;
	localparam int HORIZON_MS = 10000;
	localparam int ADDR_W     = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int AMT_W      = 48;
	localparam int HALF_W     = AMT_W / 2;
	localparam int TIME_W     = 32;
	localparam int SLOT_W     = 32;
	localparam int TOL_W      = 16;
	localparam int NWIN       = 4;
	localparam int WIN_W      = 2;
	localparam int SECS_W     = 4;
	localparam int DIV_STEPS  = 8;
	localparam int DIV_CW     = $clog2(DIV_STEPS);

	// x / 5 equals (x * RECIP5) >> RECIP5_SH for every 48-bit x.
	localparam logic [AMT_W-1:0] RECIP5    = 48'hCCCC_CCCC_CCCD;
	localparam int               RECIP5_SH = 50;

	localparam logic [TIME_W-1:0] WIN_MS [NWIN] = '{32'd1000, 32'd2000, 32'd5000, 32'd10000};
	localparam logic [SECS_W-1:0] WIN_SECS [NWIN] = '{4'd1, 4'd2, 4'd5, 4'd10};

	localparam logic [2:0] OP_HIT    = 3'd0;
	localparam logic [2:0] OP_SAMPLE = 3'd1;
	localparam logic [2:0] OP_RESET  = 3'd2;
	localparam logic [2:0] OP_DISC   = 3'd3;
	localparam logic [2:0] OP_QUERY  = 3'd4;

	typedef struct packed {
		logic [2:0]        op;
		logic [TIME_W-1:0] time_ms;
		logic [AMT_W-1:0]  amount;
	} item_t;

	typedef struct packed {
		logic [WIN_W-1:0] window_index;
		logic [AMT_W-1:0] window_sum;
		logic [AMT_W-1:0] window_rate;
		logic [AMT_W-1:0] peak_sum;
		logic [AMT_W-1:0] run_total;
		logic             last_row;
	} result_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic prune_rd;
		logic pop;
		logic walk_init;
		logic walk_rd;
		logic walk_step;
		logic div_init;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic prune_need;
		logic is_query;
		logic ring_empty;
		logic aged_out;
		logic walk_done;
		logic div_last;
		logic out_free;
		logic last_row;
	} sts_t;

	function automatic logic [ADDR_W-1:0] wrap_add(logic [ADDR_W-1:0] base,
		logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(SLOT_COUNT)) begin
			s = s - (CNT_W+1)'(SLOT_COUNT);
		end
		return s[ADDR_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] next_idx(logic [ADDR_W-1:0] x);
		logic [ADDR_W-1:0] r;
		r = (x == ADDR_W'(SLOT_COUNT - 1)) ? '0 : x + ADDR_W'(1);
		return r;
	endfunction

endpackage

@@ hw/rtl/wrm_dp.sv @@
// ----------------------------------------------------------------------------
// Windowed rate meter datapath
// Ring memory, run state, window walk, reciprocal-multiply rate divider,
// result register.
// ----------------------------------------------------------------------------
module wrm_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wrm_pkg::cmd_t                  cmd,
	output wrm_pkg::sts_t                  sts,
	input  wrm_pkg::item_t                 item,
	input  logic                           cfg_valid,
	input  logic [wrm_pkg::TOL_W-1:0]      cfg_data,
	output logic                           result_valid,
	input  logic                           result_stall,
	output wrm_pkg::result_t               result
);

	logic [wrm_pkg::SLOT_W-1:0] mem_time [wrm_pkg::SLOT_COUNT];
	logic [wrm_pkg::SLOT_W-1:0] mem_amt  [wrm_pkg::SLOT_COUNT];

	wrm_pkg::item_t               item_q;
	logic [wrm_pkg::TOL_W-1:0]    tol_q;
	logic [wrm_pkg::ADDR_W-1:0]   oldest_q;
	logic [wrm_pkg::CNT_W-1:0]    count_q;
	logic [wrm_pkg::AMT_W-1:0]    total_q;
	logic [wrm_pkg::AMT_W-1:0]    prev_q;
	logic [wrm_pkg::AMT_W-1:0]    base_q;
	logic                         bvalid_q;
	logic                         resync_q;
	logic [wrm_pkg::AMT_W-1:0]    peak_q [wrm_pkg::NWIN];
	logic [wrm_pkg::CNT_W-1:0]    walk_q;
	logic [wrm_pkg::NWIN-1:0]     stop_q;
	logic [wrm_pkg::AMT_W-1:0]    sum_q [wrm_pkg::NWIN];
	logic [wrm_pkg::AMT_W-1:0]    quo_q [wrm_pkg::NWIN];
	logic [2*wrm_pkg::AMT_W-1:0]  acc_q;
	logic [wrm_pkg::DIV_CW-1:0]   dcnt_q;
	logic [wrm_pkg::WIN_W-1:0]    row_q;
	wrm_pkg::result_t             out_q;
	logic                         out_valid_q;
	logic [wrm_pkg::SLOT_W-1:0]   rd_time_q;
	logic [wrm_pkg::SLOT_W-1:0]   rd_amt_q;

	logic [wrm_pkg::AMT_W-1:0]    amt;
	logic                         push_hit;
	logic                         push_smp;
	logic                         rebase;
	logic                         do_push;
	logic                         full;
	logic [wrm_pkg::AMT_W-1:0]    push_val;
	logic [wrm_pkg::SLOT_W-1:0]   push_sat;
	logic [wrm_pkg::ADDR_W-1:0]   wr_addr;
	logic [wrm_pkg::ADDR_W-1:0]   rd_addr;
	logic [wrm_pkg::AMT_W-1:0]    run_over;
	logic [wrm_pkg::AMT_W:0]      total_sum;
	logic [wrm_pkg::AMT_W-1:0]    total_sat;
	logic [wrm_pkg::TIME_W-1:0]   age;
	logic                         mem_re;
	logic [wrm_pkg::AMT_W-1:0]    div_x;
	logic [wrm_pkg::HALF_W-1:0]   div_a;
	logic [wrm_pkg::HALF_W-1:0]   div_m;
	logic [2*wrm_pkg::HALF_W-1:0] div_pp;
	logic [2*wrm_pkg::AMT_W-1:0]  div_pp_sh;
	logic [2*wrm_pkg::AMT_W-1:0]  div_acc_d;

	assign amt      = item_q.amount;
	assign rebase   = !bvalid_q || ({1'b0, base_q} >
		({1'b0, amt} + (wrm_pkg::AMT_W+1)'(tol_q)));
	assign push_hit = (item_q.op == wrm_pkg::OP_HIT) && (amt != '0);
	assign push_smp = (item_q.op == wrm_pkg::OP_SAMPLE) && !rebase && !resync_q &&
		(amt > prev_q);
	assign do_push  = cmd.exec && (push_hit || push_smp);
	assign full     = (count_q == wrm_pkg::CNT_W'(wrm_pkg::SLOT_COUNT));
	assign push_val = push_hit ? amt : amt - prev_q;
	assign push_sat = (push_val[wrm_pkg::AMT_W-1:wrm_pkg::SLOT_W] != '0) ? '1 :
		push_val[wrm_pkg::SLOT_W-1:0];
	assign wr_addr  = full ? oldest_q : wrm_pkg::wrap_add(oldest_q, count_q);
	assign rd_addr  = cmd.walk_rd ? wrm_pkg::wrap_add(oldest_q, walk_q - wrm_pkg::CNT_W'(1)) :
		oldest_q;
	assign mem_re   = cmd.prune_rd || cmd.walk_rd;
	assign run_over = (amt > base_q) ? amt - base_q : '0;
	assign total_sum = {1'b0, total_q} + {1'b0, amt};
	assign total_sat = total_sum[wrm_pkg::AMT_W] ? '1 : total_sum[wrm_pkg::AMT_W-1:0];
	assign age      = item_q.time_ms - rd_time_q;

	// Steps 0-3 divide the 5 s sum by 5, steps 4-7 the halved 10 s sum, one
	// 24 by 24 bit partial product per step.
	assign div_x     = dcnt_q[2] ? {1'b0, sum_q[3][wrm_pkg::AMT_W-1:1]} : sum_q[2];
	assign div_a     = dcnt_q[1] ? div_x[wrm_pkg::AMT_W-1:wrm_pkg::HALF_W] :
		div_x[wrm_pkg::HALF_W-1:0];
	assign div_m     = dcnt_q[0] ? wrm_pkg::RECIP5[wrm_pkg::AMT_W-1:wrm_pkg::HALF_W] :
		wrm_pkg::RECIP5[wrm_pkg::HALF_W-1:0];
	assign div_pp    = div_a * div_m;
	assign div_pp_sh = (dcnt_q[1:0] == 2'b00) ? (2*wrm_pkg::AMT_W)'(div_pp) :
		(dcnt_q[1:0] == 2'b11) ? {div_pp, {wrm_pkg::AMT_W{1'b0}}} :
		{{wrm_pkg::HALF_W{1'b0}}, div_pp, {wrm_pkg::HALF_W{1'b0}}};
	assign div_acc_d = ((dcnt_q[1:0] == 2'b00) ? '0 : acc_q) + div_pp_sh;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_time[wr_addr] <= item_q.time_ms;
			mem_amt[wr_addr]  <= push_sat;
		end
		if (mem_re) begin
			rd_time_q <= mem_time[rd_addr];
			rd_amt_q  <= mem_amt[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q      <= '0;
			tol_q       <= wrm_pkg::TOL_W'(128);
			oldest_q    <= '0;
			count_q     <= '0;
			total_q     <= '0;
			prev_q      <= '0;
			base_q      <= '0;
			bvalid_q    <= 1'b0;
			resync_q    <= 1'b0;
			walk_q      <= '0;
			stop_q      <= '0;
			acc_q       <= '0;
			dcnt_q      <= '0;
			row_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < wrm_pkg::NWIN; i++) begin
				peak_q[i] <= '0;
				sum_q[i]  <= '0;
				quo_q[i]  <= '0;
			end
		end else begin
			if (cfg_valid) begin
				tol_q <= cfg_data;
			end
			if (cmd.load) begin
				item_q <= item;
			end
			if (cmd.exec) begin
				case (item_q.op)
					wrm_pkg::OP_HIT: begin
						if (amt != '0) begin
							total_q <= total_sat;
						end
					end
					wrm_pkg::OP_SAMPLE: begin
						if (rebase) begin
							base_q   <= amt;
							prev_q   <= amt;
							bvalid_q <= 1'b1;
							total_q  <= '0;
							oldest_q <= '0;
							count_q  <= '0;
							for (int i = 0; i < wrm_pkg::NWIN; i++) begin
								peak_q[i] <= '0;
							end
						end else begin
							resync_q <= 1'b0;
							prev_q   <= amt;
							total_q  <= run_over;
						end
					end
					wrm_pkg::OP_RESET: begin
						oldest_q <= '0;
						count_q  <= '0;
						total_q  <= '0;
						prev_q   <= '0;
						base_q   <= '0;
						bvalid_q <= 1'b0;
						for (int i = 0; i < wrm_pkg::NWIN; i++) begin
							peak_q[i] <= '0;
						end
					end
					wrm_pkg::OP_DISC: begin
						resync_q <= 1'b1;
					end
					default: begin
					end
				endcase
				if (do_push) begin
					if (full) begin
						oldest_q <= wrm_pkg::next_idx(oldest_q);
					end else begin
						count_q <= count_q + wrm_pkg::CNT_W'(1);
					end
				end
			end
			if (cmd.pop) begin
				oldest_q <= wrm_pkg::next_idx(oldest_q);
				count_q  <= count_q - wrm_pkg::CNT_W'(1);
			end
			if (cmd.walk_init) begin
				walk_q <= count_q;
				stop_q <= '0;
				for (int i = 0; i < wrm_pkg::NWIN; i++) begin
					sum_q[i] <= '0;
				end
			end
			if (cmd.walk_step) begin
				walk_q <= walk_q - wrm_pkg::CNT_W'(1);
				for (int i = 0; i < wrm_pkg::NWIN; i++) begin
					if (!stop_q[i]) begin
						if (age > wrm_pkg::WIN_MS[i]) begin
							stop_q[i] <= 1'b1;
						end else begin
							sum_q[i] <= sum_q[i] + wrm_pkg::AMT_W'(rd_amt_q);
						end
					end
				end
			end
			if (cmd.div_init) begin
				dcnt_q   <= '0;
				row_q    <= '0;
				quo_q[0] <= sum_q[0];
				quo_q[1] <= {1'b0, sum_q[1][wrm_pkg::AMT_W-1:1]};
				for (int i = 0; i < wrm_pkg::NWIN; i++) begin
					if (sum_q[i] > peak_q[i]) begin
						peak_q[i] <= sum_q[i];
					end
				end
			end
			if (cmd.div_step) begin
				dcnt_q <= dcnt_q + wrm_pkg::DIV_CW'(1);
				acc_q  <= div_acc_d;
				if (dcnt_q[1:0] == 2'b11) begin
					if (dcnt_q[2]) begin
						quo_q[3] <= wrm_pkg::AMT_W'(
							div_acc_d[2*wrm_pkg::AMT_W-1:wrm_pkg::RECIP5_SH]);
					end else begin
						quo_q[2] <= wrm_pkg::AMT_W'(
							div_acc_d[2*wrm_pkg::AMT_W-1:wrm_pkg::RECIP5_SH]);
					end
				end
			end
			if (cmd.out_load) begin
				out_q.window_index <= row_q;
				out_q.window_sum   <= sum_q[row_q];
				out_q.window_rate  <= quo_q[row_q];
				out_q.peak_sum     <= peak_q[row_q];
				out_q.run_total    <= total_q;
				out_q.last_row     <= (row_q == wrm_pkg::WIN_W'(wrm_pkg::NWIN - 1));
				out_valid_q        <= 1'b1;
				row_q              <= row_q + wrm_pkg::WIN_W'(1);
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.prune_need = push_hit || push_smp || (item_q.op == wrm_pkg::OP_QUERY);
	assign sts.is_query   = (item_q.op == wrm_pkg::OP_QUERY);
	assign sts.ring_empty = (count_q == '0);
	assign sts.aged_out   = (age > wrm_pkg::TIME_W'(wrm_pkg::HORIZON_MS));
	assign sts.walk_done  = (walk_q == '0) || (&stop_q);
	assign sts.div_last   = (dcnt_q == wrm_pkg::DIV_CW'(wrm_pkg::DIV_STEPS - 1));
	assign sts.out_free   = !out_valid_q || !result_stall;
	assign sts.last_row   = (row_q == wrm_pkg::WIN_W'(wrm_pkg::NWIN - 1));

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= wrm_pkg::CNT_W'(wrm_pkg::SLOT_COUNT))
		else $error("Ring fill count exceeds its depth.");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.out_load && out_valid_q && result_stall))
		else $error("A waiting result item was overwritten.");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q != '0))
		else $error("Prune popped an empty ring.");

endmodule

@@ hw/rtl/wrm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Windowed rate meter controller
// Sequences execute, prune, window walk, rate division and result rows.
// ----------------------------------------------------------------------------
module wrm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  wrm_pkg::sts_t sts,
	output wrm_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_PRD  = 3'd2;
	localparam logic [2:0] S_PCK  = 3'd3;
	localparam logic [2:0] S_WRD  = 3'd4;
	localparam logic [2:0] S_WCK  = 3'd5;
	localparam logic [2:0] S_DIV  = 3'd6;
	localparam logic [2:0] S_EMIT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		item_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.prune_need ? S_PRD : S_IDLE;
			end
			S_PRD: begin
				if (sts.ring_empty) begin
					cmd.walk_init = sts.is_query;
					state_d       = sts.is_query ? S_WRD : S_IDLE;
				end else begin
					cmd.prune_rd = 1'b1;
					state_d      = S_PCK;
				end
			end
			S_PCK: begin
				if (sts.aged_out) begin
					cmd.pop = 1'b1;
					state_d = S_PRD;
				end else begin
					cmd.walk_init = sts.is_query;
					state_d       = sts.is_query ? S_WRD : S_IDLE;
				end
			end
			S_WRD: begin
				if (sts.walk_done) begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end else begin
					cmd.walk_rd = 1'b1;
					state_d     = S_WCK;
				end
			end
			S_WCK: begin
				cmd.walk_step = 1'b1;
				state_d       = S_WRD;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.last_row) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> (state_q == S_EXEC))
		else $error("Accepted item did not reach execute.");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && sts.last_row) |=> (state_q == S_IDLE))
		else $error("Controller did not return to idle after the last row.");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall == (state_q != S_IDLE))
		else $error("Input stall does not match the controller state.");

endmodule

@@ hw/rtl/windowed_rate_meter_with_peak_top.sv @@
// ----------------------------------------------------------------------------
// Windowed rate meter with held peaks, top level
// Non-query items are executed; if one pushed an entry, the ring is then pruned, each
// entry read and then age-checked. A query is pruned likewise, walks the ring back from
// the newest entry, runs the reciprocal-multiply rate divider, then emits one row per
// cycle while result_stall is low; the walk is bound by the one read port.
// Reset clears all control state and empties the ring; no clearing pass is needed.
// ----------------------------------------------------------------------------
module windowed_rate_meter_with_peak_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  wrm_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output wrm_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wrm_pkg::TOL_W-1:0]     cfg_data
);

	wrm_pkg::cmd_t cmd;
	wrm_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	wrm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	wrm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
